// ===== hdl/ils_pkg.sv =====
// Shared types and constants for the indexed LIFO stack core.
// No dependencies; used by ils_addr and indexed_lifo_stack_core.
package ils_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the stream fields
    localparam int ACT_W   = 2;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 9;
    localparam int COUNT_W = 9;
    localparam int TDATA_W = 48;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_SEEK = 2'd3
    } act_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    // Decoded request controls from the address unit
    typedef struct packed {
        logic rd;        // read one entry
        logic wr;        // write one entry
        logic hit;       // read lands on a filled entry
        logic inc;       // fill count goes up
        logic dec;       // fill count goes down
        logic overflow;  // push dropped on a full stack
    } op_flags_t;

endpackage

// ===== hdl/ils_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/ils_addr.sv =====
// Address unit: turns one request and the fill count into an entry index
// and decoded controls. Depends on ils_pkg.
module ils_addr #(
    parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
    input  ils_pkg::act_t                  action,
    input  logic signed [ils_pkg::POS_W-1:0] position,
    input  logic                           from_top,
    input  logic [$clog2(DEPTH+1)-1:0]     fill,
    output logic [$clog2(DEPTH)-1:0]       addr,
    output ils_pkg::op_flags_t             flags
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int IW = ((CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W) + 2;

    logic signed [IW-1:0] fill_s;
    logic signed [IW-1:0] pos_s;
    logic signed [IW-1:0] one_s;
    logic signed [IW-1:0] idx;
    logic                 in_range;
    logic                 full;
    logic                 empty;

    assign fill_s   = signed'({{(IW-CW){1'b0}}, fill});
    assign pos_s    = signed'({{(IW-ils_pkg::POS_W){position[ils_pkg::POS_W-1]}}, position});
    assign one_s    = signed'(IW'(1));
    assign full     = (fill == CW'(DEPTH));
    assign empty    = (fill == '0);

    always_comb begin
        case (action)
            ils_pkg::ACT_PUSH: idx = fill_s;
            ils_pkg::ACT_POP:  idx = fill_s - one_s;
            ils_pkg::ACT_PEEK: idx = fill_s - pos_s - one_s;
            default:           idx = (from_top ? (fill_s - one_s) : '0) + pos_s;
        endcase
    end

    assign in_range = !idx[IW-1] && (idx < fill_s);
    assign addr     = idx[AW-1:0];

    always_comb begin
        flags = '0;
        case (action)
            ils_pkg::ACT_PUSH: begin
                flags.wr       = !full;
                flags.inc      = !full;
                flags.overflow = full;
            end
            ils_pkg::ACT_POP: begin
                flags.rd  = !empty;
                flags.hit = !empty;
                flags.dec = !empty;
            end
            ils_pkg::ACT_PEEK: begin
                // negative depth never hits
                flags.hit = in_range && !position[ils_pkg::POS_W-1];
                flags.rd  = flags.hit;
            end
            ils_pkg::ACT_SEEK: begin
                flags.hit = in_range;
                flags.rd  = in_range;
            end
            default: flags = '0;
        endcase
    end

endmodule

// ===== hdl/indexed_lifo_stack_core.sv =====
// Indexed LIFO stack core: push, pop, peek and seek over one stack RAM.
// A request accepted in the idle state issues the registered RAM read; the
// read state loads the result register once it is free, so no new request
// is taken until then. A stalled result parks the next request in the read
// state and holds s_tready low until it drains.
// Reset (aresetn low, synchronous) empties the stack and drops any pending
// result; RAM contents are not cleared and need no clearing pass.
// Depends on ils_pkg, ils_addr and ils_ram.
module indexed_lifo_stack_core #(
    parameter int DEPTH      = ils_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata, from bit 0: data[31:0], position[40:32], from_top[41], zero fill
    input  logic [ils_pkg::TDATA_W-1:0] s_tdata,
    // s_tuser: action[1:0]
    input  logic [ils_pkg::ACT_W-1:0]   s_tuser,
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata, from bit 0: value[31:0], found[32], count[41:33],
    // overflow[42], zero fill
    output logic [ils_pkg::TDATA_W-1:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int MW = (DATA_WIDTH > ils_pkg::WORD_W) ? DATA_WIDTH : ils_pkg::WORD_W;
    localparam int XW = (CW > ils_pkg::COUNT_W) ? CW : ils_pkg::COUNT_W;
    localparam int PAD_W = ils_pkg::TDATA_W - ils_pkg::WORD_W - ils_pkg::COUNT_W - 2;

    // Request field unpacking
    ils_pkg::act_t                    in_action;
    logic [ils_pkg::WORD_W-1:0]       in_data;
    logic signed [ils_pkg::POS_W-1:0] in_position;
    logic                             in_from_top;

    assign in_action   = ils_pkg::act_t'(s_tuser);
    assign in_data     = s_tdata[ils_pkg::WORD_W-1:0];
    assign in_position = signed'(s_tdata[ils_pkg::WORD_W +: ils_pkg::POS_W]);
    assign in_from_top = s_tdata[ils_pkg::WORD_W + ils_pkg::POS_W];

    // Control state
    ils_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;
    ils_pkg::op_flags_t pend_reg;
    logic [CW-1:0]      pend_count_reg;

    // Result register
    logic                       m_valid_reg, m_valid_next;
    logic [ils_pkg::WORD_W-1:0] value_reg;
    logic                       found_reg;
    logic [ils_pkg::COUNT_W-1:0] count_reg;
    logic                       over_reg;

    ils_pkg::op_flags_t flags;
    logic [AW-1:0]      addr;
    logic [DATA_WIDTH-1:0] rdata;
    logic [DATA_WIDTH-1:0] wdata;
    logic [MW-1:0]      wext;
    logic [MW-1:0]      rext;
    logic [XW-1:0]      cext;
    logic               in_fire;
    logic               load_out;

    assign in_fire = s_tvalid && s_tready;

    // Decode the request against the current fill count
    ils_addr #(
        .DEPTH (DEPTH)
    ) u_addr (
        .action   (in_action),
        .position (in_position),
        .from_top (in_from_top),
        .fill     (fill_reg),
        .addr     (addr),
        .flags    (flags)
    );

    // Drop data bits above DATA_WIDTH on push
    assign wext  = MW'(in_data);
    assign wdata = wext[DATA_WIDTH-1:0];

    // A write lands at accept; any later read is issued at a later accept,
    // so the RAM always returns the committed word and no bypass is
    // needed.
    ils_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (in_fire && flags.wr),
        .waddr (addr),
        .wdata (wdata),
        .re    (in_fire && flags.rd),
        .raddr (addr),
        .rdata (rdata)
    );

    // Next state, fill count and result handoff
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        load_out     = 1'b0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ils_pkg::ST_IDLE: begin
                // take a request even while the last result still waits
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ils_pkg::ST_READ;
                    if (flags.inc) begin
                        fill_next = fill_reg + CW'(1);
                    end else if (flags.dec) begin
                        fill_next = fill_reg - CW'(1);
                    end
                end
            end
            ils_pkg::ST_READ: begin
                // hold RAM data until the result register is free
                if (!m_valid_reg || m_tready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ils_pkg::ST_IDLE;
                end
            end
            default: state_next = ils_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ils_pkg::ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture request outcome at accept
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pend_reg       <= flags;
            pend_count_reg <= fill_next;
        end
    end

    assign rext = MW'(rdata);
    assign cext = XW'(pend_count_reg);

    always_ff @(posedge aclk) begin
        if (load_out) begin
            value_reg <= pend_reg.hit ? rext[ils_pkg::WORD_W-1:0] : '0;
            found_reg <= pend_reg.hit;
            count_reg <= cext[ils_pkg::COUNT_W-1:0];
            over_reg  <= pend_reg.overflow;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, over_reg, count_reg, found_reg, value_reg};

    // Fill count never passes the stack depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above DEPTH");

    // A dropped push leaves the fill count untouched
    a_overflow_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && flags.overflow) |=> $stable(fill_reg))
        else $error("overflowing push changed fill count");

    // A stalled result keeps the pending read parked
    a_read_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ils_pkg::ST_READ && m_tvalid && !m_tready)
        |=> (state_reg == ils_pkg::ST_READ))
        else $error("pending read left while result stalled");

endmodule
